>>> rtl/gdn_pkg.sv
// Shared types, constants and tables of the Gregorian date / day number converter.
// Depends on nothing; every other file but the checker refers to it by scoped names.
package gdn_pkg;

	// Pipeline depth, from the input register to the output register.
	localparam int STAGES = 12;

	typedef enum logic {
		CMD_TO_DAY_NUMBER = 1'b0,
		CMD_TO_DATE       = 1'b1
	} cmd_t;

	// Calendar constants of the day number algorithm.
	localparam int EPOCH_YEAR = 4800;
	localparam int JDN_OFFSET = 32045;
	localparam int JDN_SHIFT  = 32044;
	localparam int ERA_DAYS   = 146097;
	localparam int CENT_DAYS  = 36524;
	localparam int QUAD_DAYS  = 1461;
	localparam int YEAR_DAYS  = 365;

	// Reciprocals for division by constants: q = (x * K) >> SH, exact for the operand width used.
	localparam int          SH_DIV100 = 19;
	localparam logic [12:0] K_DIV100  = 13'(((64'd1 << SH_DIV100) + 64'd99) / 64'd100);
	localparam int          SH_ERA    = 43;
	localparam logic [25:0] K_ERA     = 26'(((64'd1 << SH_ERA) + 64'd146096) / 64'd146097);
	localparam int          SH_QUAD   = 27;
	localparam logic [16:0] K_QUAD    = 17'(((64'd1 << SH_QUAD) + 64'd1460) / 64'd1461);
	localparam int          SH_DIV153 = 20;
	localparam logic [12:0] K_DIV153  = 13'(((64'd1 << SH_DIV153) + 64'd152) / 64'd153);

	// What travels beside the arithmetic: the request and the forward result.
	typedef struct packed {
		cmd_t               cmd;
		logic signed [15:0] year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic signed [24:0] day_number;
		logic               neg;
	} side_t;

	// Days from March 1 to the first day of month index m, where March is index 0.
	function automatic logic [8:0] month_offset(input logic [3:0] m);
		logic [8:0] r;
		unique case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/gdn_fwd.sv
// Stages one to three: date to day number, and choice of the day number to decompose.
// Depends on gdn_pkg.
module gdn_fwd (
	input  logic               clk,
	input  logic [2:0]         en,
	input  gdn_pkg::cmd_t      cmd,
	input  logic signed [15:0] year,
	input  logic [3:0]         month,
	input  logic [4:0]         day,
	input  logic [23:0]        day_number,
	output logic [24:0]        j,
	output gdn_pkg::side_t     side
);

	logic               early;
	logic [3:0]         m_idx;
	logic signed [16:0] y_next;
	logic [8:0]         dm_next;

	logic signed [16:0] y_s1;
	logic [8:0]         dm_s1;
	logic [23:0]        dn_s1;
	gdn_pkg::side_t     side_s1;

	logic [15:0]        yu;
	logic [28:0]        p100;
	logic [26:0]        p400;

	logic [23:0]        sum_s2;
	logic [9:0]         q100_s2;
	logic [7:0]         q400_s2;
	logic [24:0]        dnj_s2;
	logic               yneg_s2;
	gdn_pkg::side_t     side_s2;

	logic signed [25:0] t_sum;
	logic signed [25:0] jdn;
	logic [25:0]        jf;
	logic               neg;
	gdn_pkg::side_t     side_next;

	logic [24:0]        j_s3;
	gdn_pkg::side_t     side_s3;

	// January and February count as months 10 and 11 of the previous year.
	assign early   = (month <= 4'd2);
	assign m_idx   = early ? month + 4'd9 : month - 4'd3;
	assign y_next  = 17'(year) + 17'(gdn_pkg::EPOCH_YEAR) - {16'd0, early};
	assign dm_next = {4'd0, day} + gdn_pkg::month_offset(m_idx);

	assign yu   = y_s1[15:0];
	assign p100 = 29'(yu) * 29'(gdn_pkg::K_DIV100);
	assign p400 = 27'(yu[15:2]) * 27'(gdn_pkg::K_DIV100);

	// A negative shifted year always gives a day number below zero.
	assign t_sum = 26'(sum_s2) - 26'(q100_s2) + 26'(q400_s2);
	assign jdn   = t_sum - 26'(gdn_pkg::JDN_OFFSET);
	assign jf    = 26'(t_sum) - 26'd1;
	assign neg   = yneg_s2 | jdn[25];

	always_comb begin
		side_next     = side_s2;
		side_next.neg = neg;
		unique case (side_s2.cmd)
			gdn_pkg::CMD_TO_DATE: begin
				side_next.day_number = '0;
			end
			gdn_pkg::CMD_TO_DAY_NUMBER: begin
				side_next.day_number = neg ? '1 : jdn[24:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			y_s1    <= y_next;
			dm_s1   <= dm_next;
			dn_s1   <= day_number;
			side_s1 <= '{cmd: cmd, year: year, month: month, day: day,
				day_number: '0, neg: 1'b0};
		end
		if (en[1]) begin
			sum_s2  <= 24'(yu) * 24'(gdn_pkg::YEAR_DAYS) + 24'(yu[15:2]) + 24'(dm_s1);
			q100_s2 <= p100[28:19];
			q400_s2 <= p400[26:19];
			dnj_s2  <= 25'(dn_s1) + 25'(gdn_pkg::JDN_SHIFT);
			yneg_s2 <= y_s1[16];
			side_s2 <= side_s1;
		end
		if (en[2]) begin
			j_s3    <= (side_s2.cmd == gdn_pkg::CMD_TO_DATE) ? dnj_s2 : jf[24:0];
			side_s3 <= side_next;
		end
	end

	assign j    = j_s3;
	assign side = side_s3;

endmodule

>>> rtl/gdn_split.sv
// Stages four to nine: splits a shifted day number into eras, centuries, leap cycles and years.
// Depends on gdn_pkg.
module gdn_split (
	input  logic           clk,
	input  logic [5:0]     en,
	input  logic [24:0]    j,
	input  gdn_pkg::side_t side_in,
	output logic [8:0]     da,
	output logic [16:0]    yacc,
	output gdn_pkg::side_t side_out
);

	logic [50:0]    p_era;
	logic [24:0]    g_days;
	logic [1:0]     c;
	logic [17:0]    c_days;
	logic [32:0]    p_quad;
	logic [15:0]    b_days;
	logic [1:0]     a;
	logic [10:0]    a_days;

	logic [7:0]     g_s4;
	logic [24:0]    j_s4;
	gdn_pkg::side_t side_s4;

	logic [17:0]    dg_s5;
	logic [16:0]    yacc_s5;
	gdn_pkg::side_t side_s5;

	logic [15:0]    dc_s6;
	logic [16:0]    yacc_s6;
	gdn_pkg::side_t side_s6;

	logic [5:0]     b_s7;
	logic [15:0]    dc_s7;
	logic [16:0]    yacc_s7;
	gdn_pkg::side_t side_s7;

	logic [10:0]    db_s8;
	logic [16:0]    yacc_s8;
	gdn_pkg::side_t side_s8;

	logic [8:0]     da_s9;
	logic [16:0]    yacc_s9;
	gdn_pkg::side_t side_s9;

	assign p_era  = 51'(j) * 51'(gdn_pkg::K_ERA);
	assign g_days = 25'(g_s4) * 25'(gdn_pkg::ERA_DAYS);

	// The fourth century of an era may run one day long; the count stops at three.
	always_comb begin
		priority if (dg_s5 >= 18'(3 * gdn_pkg::CENT_DAYS)) c = 2'd3;
		else if (dg_s5 >= 18'(2 * gdn_pkg::CENT_DAYS))     c = 2'd2;
		else if (dg_s5 >= 18'(gdn_pkg::CENT_DAYS))         c = 2'd1;
		else                                               c = 2'd0;
	end
	assign c_days = 18'(c) * 18'(gdn_pkg::CENT_DAYS);

	assign p_quad = 33'(dc_s6) * 33'(gdn_pkg::K_QUAD);
	assign b_days = 16'(b_s7) * 16'(gdn_pkg::QUAD_DAYS);

	// Same for the leap day at the end of a four-year cycle.
	always_comb begin
		priority if (db_s8 >= 11'(3 * gdn_pkg::YEAR_DAYS)) a = 2'd3;
		else if (db_s8 >= 11'(2 * gdn_pkg::YEAR_DAYS))     a = 2'd2;
		else if (db_s8 >= 11'(gdn_pkg::YEAR_DAYS))         a = 2'd1;
		else                                               a = 2'd0;
	end
	assign a_days = 11'(a) * 11'(gdn_pkg::YEAR_DAYS);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			g_s4    <= p_era[50:43];
			j_s4    <= j;
			side_s4 <= side_in;
		end
		if (en[1]) begin
			dg_s5   <= 18'(j_s4 - g_days);
			yacc_s5 <= 17'(g_s4) * 17'd400;
			side_s5 <= side_s4;
		end
		if (en[2]) begin
			dc_s6   <= 16'(dg_s5 - c_days);
			yacc_s6 <= yacc_s5 + 17'(c) * 17'd100;
			side_s6 <= side_s5;
		end
		if (en[3]) begin
			b_s7    <= p_quad[32:27];
			dc_s7   <= dc_s6;
			yacc_s7 <= yacc_s6;
			side_s7 <= side_s6;
		end
		if (en[4]) begin
			db_s8   <= 11'(dc_s7 - b_days);
			yacc_s8 <= yacc_s7 + {9'd0, b_s7, 2'b00};
			side_s8 <= side_s7;
		end
		if (en[5]) begin
			da_s9   <= 9'(db_s8 - a_days);
			yacc_s9 <= yacc_s8 + 17'(a);
			side_s9 <= side_s8;
		end
	end

	assign da       = da_s9;
	assign yacc     = yacc_s9;
	assign side_out = side_s9;

endmodule

>>> rtl/gdn_date.sv
// Stages ten and eleven: day of a March-based year to calendar year, month and day.
// Depends on gdn_pkg.
module gdn_date (
	input  logic               clk,
	input  logic [1:0]         en,
	input  logic [8:0]         da,
	input  logic [16:0]        yacc,
	input  gdn_pkg::side_t     side_in,
	output logic signed [15:0] ry,
	output logic [3:0]         rm,
	output logic [4:0]         rd,
	output gdn_pkg::side_t     side_out
);

	logic [11:0]        mx;
	logic [24:0]        pm;
	logic [4:0]         mq;
	logic               carry;

	logic [3:0]         m_s10;
	logic [8:0]         da_s10;
	logic [16:0]        yacc_s10;
	gdn_pkg::side_t     side_s10;

	logic signed [15:0] ry_s11;
	logic [3:0]         rm_s11;
	logic [4:0]         rd_s11;
	gdn_pkg::side_t     side_s11;

	assign mx = 12'(da) * 12'd5 + 12'd308;
	assign pm = 25'(mx) * 25'(gdn_pkg::K_DIV153);
	assign mq = pm[24:20];

	// Month indexes ten and eleven are January and February of the next year.
	assign carry = (m_s10 >= 4'd10);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			m_s10    <= 4'(mq - 5'd2);
			da_s10   <= da;
			yacc_s10 <= yacc;
			side_s10 <= side_in;
		end
		if (en[1]) begin
			rd_s11   <= 5'(da_s10 - gdn_pkg::month_offset(m_s10) + 9'd1);
			rm_s11   <= carry ? m_s10 - 4'd9 : m_s10 + 4'd3;
			ry_s11   <= 16'(yacc_s10 - 17'(gdn_pkg::EPOCH_YEAR) + 17'(carry));
			side_s11 <= side_s10;
		end
	end

	assign ry       = ry_s11;
	assign rm       = rm_s11;
	assign rd       = rd_s11;
	assign side_out = side_s11;

endmodule

>>> rtl/gregorian_day_number_convert.sv
// Top level of the proleptic Gregorian date / Julian day number converter.
// Depends on gdn_pkg, gdn_fwd, gdn_split and gdn_date.
//
// This block converts in either direction between a proleptic Gregorian date (astronomical
// year numbering) and a Julian day number, one transaction per clock cycle while the
// output side keeps up. With tuser low a transaction carries a year, month and day; the
// result is the day number and a valid flag that is set only when the day number is not
// negative and converting it back yields the very same date, so impossible dates such as
// month 13 or February 30 come out with the flag clear. Day numbers below zero are
// reported as -1. With tuser high a transaction carries a day number and the result is the
// year, month and day, with the flag always set; years past 32767 wrap in the 16-bit year
// field. Result fields that do not belong to the command are zero. Both directions share
// one twelve-stage pipeline: three stages of date to day number arithmetic, six stages
// that split a day number into 400-year eras, centuries, four-year cycles and years, two
// stages that form the month and day, and the output register. Every stage holds one
// transaction and advances whenever the stage after it is empty or moving, so an input is
// taken on every cycle that the output is taken, and also while a finished result waits,
// as long as an earlier stage is empty.
module gregorian_day_number_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata, lowest bit up: in_year[15:0], in_month[19:16], in_day[24:20],
	// in_day_number[48:25], zero pad [55:49]
	input  logic [55:0] s_axis_tdata,
	// tuser: command (0 = date to day number, 1 = day number to date)
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata, lowest bit up: out_day_number[24:0], out_year[40:25], out_month[44:41],
	// out_day[49:45], zero pad [55:50]
	output logic [55:0] m_axis_tdata,
	// tuser: valid_res
	output logic        m_axis_tuser
);

	localparam int ST = gdn_pkg::STAGES;

	logic [ST-1:0]      vld_q;
	logic [ST-1:0]      en;

	logic [24:0]        j_fwd;
	gdn_pkg::side_t     side_fwd;
	logic [8:0]         da_spl;
	logic [16:0]        yacc_spl;
	gdn_pkg::side_t     side_spl;
	logic signed [15:0] ry;
	logic [3:0]         rm;
	logic [4:0]         rd;
	gdn_pkg::side_t     side_dat;

	logic               ok;
	logic signed [24:0] dn_next;
	logic signed [15:0] year_next;
	logic [3:0]         month_next;
	logic [4:0]         day_next;
	logic               res_next;

	logic signed [24:0] dn_s12;
	logic signed [15:0] year_s12;
	logic [3:0]         month_s12;
	logic [4:0]         day_s12;
	logic               res_s12;

	// A stage may load when it, or any stage after it, is empty, or when the output moves.
	genvar k;
	generate
		for (k = 0; k < ST; k++) begin : g_en
			assign en[k] = m_axis_tready || !(&vld_q[ST-1:k]);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < ST; i++) begin
				if (en[i]) begin
					vld_q[i] <= (i == 0) ? s_axis_tvalid : vld_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	assign s_axis_tready = en[0];

	gdn_fwd u_fwd (
		.clk        (clk),
		.en         (en[2:0]),
		.cmd        (gdn_pkg::cmd_t'(s_axis_tuser)),
		.year       (s_axis_tdata[15:0]),
		.month      (s_axis_tdata[19:16]),
		.day        (s_axis_tdata[24:20]),
		.day_number (s_axis_tdata[48:25]),
		.j          (j_fwd),
		.side       (side_fwd)
	);

	gdn_split u_split (
		.clk      (clk),
		.en       (en[8:3]),
		.j        (j_fwd),
		.side_in  (side_fwd),
		.da       (da_spl),
		.yacc     (yacc_spl),
		.side_out (side_spl)
	);

	gdn_date u_date (
		.clk      (clk),
		.en       (en[10:9]),
		.da       (da_spl),
		.yacc     (yacc_spl),
		.side_in  (side_spl),
		.ry       (ry),
		.rm       (rm),
		.rd       (rd),
		.side_out (side_dat)
	);

	// The round trip check: the date that comes back must match the one that went in.
	assign ok = !side_dat.neg && (ry == side_dat.year) && (rm == side_dat.month)
		&& (rd == side_dat.day);

	always_comb begin
		dn_next = side_dat.day_number;
		unique case (side_dat.cmd)
			gdn_pkg::CMD_TO_DAY_NUMBER: begin
				year_next  = '0;
				month_next = '0;
				day_next   = '0;
				res_next   = ok;
			end
			gdn_pkg::CMD_TO_DATE: begin
				year_next  = ry;
				month_next = rm;
				day_next   = rd;
				res_next   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[ST-1]) begin
			dn_s12    <= dn_next;
			year_s12  <= year_next;
			month_s12 <= month_next;
			day_s12   <= day_next;
			res_s12   <= res_next;
		end
	end

	assign m_axis_tvalid = vld_q[ST-1];
	assign m_axis_tdata  = {6'd0, day_s12, month_s12, year_s12, dn_s12};
	assign m_axis_tuser  = res_s12;

endmodule

>>> rtl/gdn_checker.sv
// Port-level checks of the Gregorian date / day number converter, and their binding.
// Depends on gregorian_day_number_convert for the bind target; uses no package.
module gdn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A result that is not taken stays on the bus unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// The only negative day number is the saturated -1, and it is never valid.
	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[24] |-> (m_axis_tdata[23:0] == 24'hFFFFFF)
			&& !m_axis_tuser)
		else $error("negative day number other than -1, or flagged valid");

	// An invalid result comes from a date conversion, whose date fields are zero.
	a_inv: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[49:25] == 25'd0))
		else $error("invalid result carries date fields");

	// A month marks a valid day number conversion, month 1 to 12 and a nonzero day.
	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[44:41] != 4'd0) |-> (m_axis_tdata[24:0] == 25'd0)
			&& (m_axis_tdata[44:41] <= 4'd12) && (m_axis_tdata[49:45] != 5'd0) && m_axis_tuser)
		else $error("date result out of range or mixed with a day number");

endmodule

bind gregorian_day_number_convert gdn_checker u_gdn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
